// ----- hw/rtl/tcw_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = COLUMNS * ROWS;

    // Field widths
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;

    // Cell memory addressing and sweep counting
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CNT_W  = $clog2(NCELLS + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT          = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_EOL    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_SCREEN = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CELL    = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    typedef struct packed {
        logic accept;    // input transfer, latch the item
        logic exec;      // carry out the latched operation
        logic sweep_en;  // write one blank cell of the sweep
        logic load_out;  // load the result register
    } tcw_cmd_t;

    typedef struct packed {
        logic sweep_last;  // sweep is on its final cell
        logic need_fill;   // operation in hand starts a sweep
    } tcw_status_t;

endpackage

// ----- hw/rtl/tcw_in_if.sv -----
// Request channel interface: operation item from the source to the console.
interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  query_row;
    logic [COL_W-1:0]  query_column;

    modport source (output valid, output opcode, output char_code, output query_row,
                    output query_column, input ready);
    modport sink (input valid, input opcode, input char_code, input query_row,
                  input query_column, output ready);
endinterface

// ----- hw/rtl/tcw_out_if.sv -----
// Response channel interface: cursor report and read-back cell from the console.
interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, output cursor_column, output cursor_row,
                    output cursor_offset, output cell_value, input ready);
    modport sink (input valid, input cursor_column, input cursor_row,
                  input cursor_offset, input cell_value, output ready);
endinterface

// ----- hw/rtl/tcw_datapath.sv -----
// Datapath: cell memory, cursor, scroll base row, blanking sweep and result register.
module tcw_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_write_data,
    input  logic [tcw_pkg::OP_W-1:0]    opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   query_row,
    input  logic [tcw_pkg::COL_W-1:0]   query_column,
    input  tcw_pkg::tcw_cmd_t           cmd,
    output tcw_pkg::tcw_status_t        status,
    output logic [tcw_pkg::COL_W-1:0]   cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::OFF_W-1:0]   cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]  cell_value
);
    import tcw_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [CELL_W-1:0] mem [NCELLS];

    logic [ATTR_W-1:0] color_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [ROW_W-1:0]  qr_reg;
    logic [COL_W-1:0]  qc_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [CNT_W-1:0]  sweep_left_reg;
    logic [ATTR_W-1:0] sweep_attr_reg;
    logic              cell_sel_reg, cell_sel_next;
    logic [CELL_W-1:0] rdata_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [CELL_W-1:0] out_cell_reg;

    logic [ROW_W-1:0]  cur_prow, q_prow, top_inc;
    logic [ADDR_W-1:0] cur_addr, q_addr, top_addr;
    logic              exec_we, rd_en, start_sweep, line_adv;
    logic [ADDR_W-1:0] sw_addr;
    logic [CNT_W-1:0]  sw_cnt;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    // Logical row to physical row: the screen is a ring of rows starting at top_reg
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (32'(s) >= ROWS)
            s = s - (ROW_W+1)'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    assign cur_prow = phys_row(row_reg, top_reg);
    assign q_prow   = phys_row(qr_reg, top_reg);
    assign cur_addr = ADDR_W'(32'(cur_prow) * COLUMNS + 32'(col_reg));
    assign q_addr   = ADDR_W'(32'(q_prow) * COLUMNS + 32'(qc_reg));
    assign top_addr = ADDR_W'(32'(top_reg) * COLUMNS);
    assign top_inc  = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        top_next      = top_reg;
        exec_we       = 1'b0;
        rd_en         = 1'b0;
        start_sweep   = 1'b0;
        line_adv      = 1'b0;
        cell_sel_next = 1'b0;
        sw_addr       = cur_addr;
        sw_cnt        = CNT_W'(COLUMNS - 32'(col_reg));
        unique case (op_reg)
            OP_PUT:
            begin
                if (ch_reg == CH_CR)
                    col_next = '0;
                else if (ch_reg == CH_LF)
                begin
                    col_next = '0;
                    line_adv = 1'b1;
                end
                else if (ch_reg != CH_BELL)
                begin
                    exec_we = 1'b1;
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        line_adv = 1'b1;
                    end
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            OP_BACKSPACE:
            begin
                if (col_reg != '0)
                    col_next = col_reg - 1'b1;
            end
            OP_CLEAR_EOL:
                start_sweep = 1'b1;
            OP_CLEAR_SCREEN:
            begin
                start_sweep = 1'b1;
                sw_addr     = '0;
                sw_cnt      = CNT_W'(NCELLS);
                col_next    = '0;
                row_next    = '0;
                top_next    = '0;
            end
            OP_READ_CELL:
            begin
                if (32'(qr_reg) < ROWS && 32'(qc_reg) < COLUMNS)
                begin
                    rd_en         = 1'b1;
                    cell_sel_next = 1'b1;
                end
            end
            default:
                ;
        endcase
        // Line advance (line feed or wrap) at the bottom: old top row becomes the blanked last line
        if (line_adv)
        begin
            if (row_reg == ROW_LAST)
            begin
                start_sweep = 1'b1;
                sw_addr     = top_addr;
                sw_cnt      = CNT_W'(COLUMNS);
                top_next    = top_inc;
            end
            else
                row_next = row_reg + 1'b1;
        end
    end

    assign status.need_fill  = start_sweep;
    assign status.sweep_last = (sweep_left_reg == CNT_W'(1));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {color_reg, ch_reg};
        if (cmd.sweep_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = {sweep_attr_reg, CH_BLANK};
        end
        else if (cmd.exec && exec_we)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.exec && rd_en)
            rdata_reg <= mem[q_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg      <= RESET_ATTR;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= CNT_W'(NCELLS);
            sweep_attr_reg <= RESET_ATTR;
        end
        else
        begin
            if (cfg_write_en)
                color_reg <= cfg_write_data;
            if (cmd.exec)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                top_reg <= top_next;
            end
            if (cmd.exec && start_sweep)
            begin
                sweep_addr_reg <= sw_addr;
                sweep_left_reg <= sw_cnt;
                sweep_attr_reg <= color_reg;
            end
            else if (cmd.sweep_en)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                sweep_left_reg <= sweep_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= opcode;
            ch_reg <= char_code;
            qr_reg <= query_row;
            qc_reg <= query_column;
        end
        if (cmd.exec)
            cell_sel_reg <= cell_sel_next;
        if (cmd.load_out)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_off_reg  <= OFF_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
            out_cell_reg <= cell_sel_reg ? rdata_reg : '0;
        end
    end

    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_offset = out_off_reg;
    assign cell_value    = out_cell_reg;

endmodule

// ----- hw/rtl/tcw_controller.sv -----
// Controller: sequences reset clear, item execution, blanking sweeps and result hand-off.
module tcw_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tcw_pkg::tcw_status_t  status,
    output tcw_pkg::tcw_cmd_t     cmd
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_EXEC = 5'b00100,
        S_FILL = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free     = !out_valid_reg || out_ready;
    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.accept   = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.sweep_en = (state_reg == S_INIT) || (state_reg == S_FILL);
    assign cmd.load_out = (state_reg == S_EMIT) && out_free;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (status.sweep_last) state_next = S_IDLE;
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = status.need_fill ? S_FILL : S_EMIT;
            S_FILL: if (status.sweep_last) state_next = S_EMIT;
            S_EMIT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_EXEC)
        else $error("accepted item not executed next cycle");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise valid");

    a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && !status.sweep_last) |=> state_reg == S_FILL)
        else $error("sweep left before its last cell");

    a_init_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT && status.sweep_last) |=> state_reg == S_IDLE)
        else $error("reset clear did not finish into idle");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_en || cmd.exec) |-> !in_ready)
        else $error("input ready while busy");

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// Top level of the text console writer: controller, datapath and channel hook-up.
// Usage:
//   req (sink): one operation per transfer - put char, backspace, clear to line end,
//     clear screen or read cell, with char_code and the query row/column.
//   rsp (source): one result per request - cursor column, row, linear offset and the
//     read-back cell (zero for anything but an in-range read).
//   cfg_write_en/cfg_write_data: attribute byte for written and blanked cells;
//     write only while no request is outstanding.
// Sequence: a transferred request goes through the execute state, then the emit state,
//   where its result is loaded once the result register is free; a blanking sweep puts
//   a fill state between the two. A scroll blanks COLUMNS cells (the recycled row), clear
//   to line end blanks COLUMNS minus the cursor column, clear screen ROWS*COLUMNS (2000),
//   one cell per cycle through the single write port of the cell memory. One request is in
//   hand at a time; the next is taken the cycle after its result is loaded.
// Scrolling moves a base-row pointer instead of copying the screen.
// Reset: the memory is cleared to blanks with attribute 7 over all ROWS*COLUMNS (2000)
//   cells, during which req.ready stays low; configuration writes are still taken.
// Stall: if rsp is not taken, the result holds in its register and a finished
//   following request waits in the controller until the register frees.
module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    tcw_in_if.sink                      req,
    tcw_out_if.source                   rsp,
    input  logic                        cfg_write_en,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_write_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;

    tcw_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (req.opcode),
        .char_code      (req.char_code),
        .query_row      (req.query_row),
        .query_column   (req.query_column),
        .cmd            (cmd),
        .status         (status),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .cursor_offset  (cursor_offset),
        .cell_value     (cell_value)
    );

    assign req.ready         = in_ready;
    assign rsp.valid         = out_valid;
    assign rsp.cursor_column = cursor_column;
    assign rsp.cursor_row    = cursor_row;
    assign rsp.cursor_offset = cursor_offset;
    assign rsp.cell_value    = cell_value;

endmodule
